// ===== src/emgbp_pkg.sv =====
// Shared types, widths, filter coefficients and helpers for the EMG bandpass/envelope block.
// Self-contained; imported by the top level.
package emgbp_pkg;

  // Item field widths
  localparam int RAW_W      = 12;
  localparam int FILT_W     = 14;
  localparam int ENV_W      = 14;
  localparam int MAG_W      = 13;
  localparam int OUT_LIMIT  = 8191;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_PAD_W  = OUT_DATA_W - FILT_W - ENV_W;

  // Filter arithmetic
  localparam int SECTIONS = 4;
  localparam int SEC_W    = 2;
  localparam int COEF_W   = 25;   // Q2.22 plus sign, +2.0 exact
  localparam int VAL_W    = 40;   // Q24.16 section values
  localparam int FRAC_W   = 16;
  localparam int WHOLE_W  = VAL_W - FRAC_W;
  localparam int HALF_W   = 20;   // value split into two halves for the multiplier
  localparam int OPH_W    = HALF_W + 1;
  localparam int PROD_W   = COEF_W + OPH_W;
  localparam int PACC_W   = PROD_W - HALF_W;
  localparam int MSUM_W   = PROD_W + 1;
  localparam int ACC_W    = MSUM_W - 2;
  localparam int PIDX_W   = 3;
  localparam int DCNT_W   = 4;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // Product slots within one section, in issue order
  localparam logic [PIDX_W-1:0] P_FB1 = 3'd0;  // f1 * d1
  localparam logic [PIDX_W-1:0] P_FB2 = 3'd1;  // f2 * d2
  localparam logic [PIDX_W-1:0] P_FF1 = 3'd2;  // b1 * d1
  localparam logic [PIDX_W-1:0] P_FF2 = 3'd3;  // b2 * d2
  localparam logic [PIDX_W-1:0] P_FF0 = 3'd4;  // b0 * w

  localparam coef_t FB_ONE [SECTIONS] = '{
    25'sd2315062, 25'sd3608635, 25'sd1567296, 25'sd4848665};
  localparam coef_t FB_TWO [SECTIONS] = '{
    -25'sd2535948, -25'sd2663884, -25'sd3407818, -25'sd3555159};
  localparam coef_t FF_ZERO [SECTIONS] = '{
    25'sd9374, 25'sd4194304, 25'sd4194304, 25'sd4194304};
  localparam coef_t FF_ONE [SECTIONS] = '{
    25'sd18748, 25'sd8388608, -25'sd8388608, -25'sd8388608};
  localparam coef_t FF_TWO [SECTIONS] = '{
    25'sd9374, 25'sd4194304, 25'sd4194304, 25'sd4194304};

  function automatic coef_t coef_of(input logic [SEC_W-1:0] sec,
                                    input logic [PIDX_W-1:0] pidx);
    coef_t c;
    unique case (pidx)
      P_FB1:   c = FB_ONE[sec];
      P_FB2:   c = FB_TWO[sec];
      P_FF1:   c = FF_ONE[sec];
      P_FF2:   c = FF_TWO[sec];
      P_FF0:   c = FF_ZERO[sec];
      default: c = '0;
    endcase
    return c;
  endfunction

  // Clamp an accumulator to the 40-bit section value range.
  function automatic val_t sat_val(input acc_t v);
    logic fits;
    fits = (&v[ACC_W-1:VAL_W-1]) || (~|v[ACC_W-1:VAL_W-1]);
    if (fits) begin
      return v[VAL_W-1:0];
    end
    return v[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
  endfunction

endpackage

// ===== src/emgbp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module emgbp_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/emg_bandpass_envelope_top.sv =====
// Top level of the EMG bandpass filter with moving-average envelope.
// Uses emgbp_pkg (types, coefficients, saturation) and emgbp_ram (window store).

// Each input item carries one converter sample and the electrode wear bit; each
// item yields exactly one result item (filtered value, envelope, wear bit).
// The sample runs through four biquad sections (8th-order bandpass) on a single
// shared 25x21 signed multiplier: every coefficient product is done as a low-half
// and a high-half pass, for the 20 products per sample. After that come the tail
// states (merge the last halves, last section output), truncate/clamp/rectify,
// the window update, the envelope (divide by WINDOW_DEPTH as a constant reciprocal
// multiply), then the load of the output register. A new item is taken only after
// the previous one has been loaded into the output register. The output load
// waits while the previous result is still held by the sink, which stalls the item.
// s_axis_tready is high only while the sequencer is idle and reset is low; the
// output register lets a new item in while the previous result still waits. The
// window store is a RAM whose stale contents are masked by a wrap flag until the
// first full pass, so no clearing sweep is needed after reset.
module emg_bandpass_envelope_top
  import emgbp_pkg::*;
#(
  parameter int WINDOW_DEPTH = 64,
  parameter int SAMPLE_BITS  = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [11:0] raw_sample, rest zero
  input  logic [0:0]            s_axis_tuser,  // [0] wear_detect
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [13:0] filtered_value, [27:14] envelope_value
  output logic [0:0]            m_axis_tuser   // [0] wear_flag
);

  localparam int SLOT_W    = $clog2(WINDOW_DEPTH);
  localparam int SUM_W     = MAG_W + SLOT_W;
  localparam int USED_BITS = (SAMPLE_BITS < RAW_W) ? SAMPLE_BITS : RAW_W;
  localparam logic [RAW_W-1:0] RAW_MASK = RAW_W'((1 << USED_BITS) - 1);
  localparam logic [SUM_W-1:0] SUM_MAX  = SUM_W'(OUT_LIMIT * WINDOW_DEPTH);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);
  localparam logic signed [WHOLE_W-1:0] LIM_POS = WHOLE_W'(OUT_LIMIT);
  localparam logic signed [WHOLE_W-1:0] LIM_NEG = -WHOLE_W'(OUT_LIMIT);

  // floor(sum / WINDOW_DEPTH) = (sum * RECIP) >> RECIP_SH, exact for any sum
  // below 2^SUM_W with RECIP = ceil(2^RECIP_SH / WINDOW_DEPTH)
  localparam int RECIP_SH = SUM_W + SLOT_W;
  localparam int RECIP_W  = SUM_W + 1;
  localparam int EPROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
    ((64'd1 << RECIP_SH) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH));

  // Sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RUN   = 4'd1;  // product stream, low and high half pass per product
  localparam logic [3:0] ST_TAILA = 4'd2;  // merge halves of the last product
  localparam logic [3:0] ST_TAILB = 4'd3;  // last section output
  localparam logic [3:0] ST_POST  = 4'd4;  // truncate, clamp, rectify
  localparam logic [3:0] ST_WIN   = 4'd5;  // window store and running sum
  localparam logic [3:0] ST_ENV   = 4'd6;  // window mean by reciprocal multiply
  localparam logic [3:0] ST_OUT   = 4'd7;

  logic [3:0]        state;
  logic [SEC_W-1:0]  sec;
  logic [PIDX_W-1:0] pidx;
  logic              phase;     // 0: low half pass, 1: high half pass

  val_t dly1 [SECTIONS];
  val_t dly2 [SECTIONS];
  logic [SUM_W-1:0]  window_sum;
  logic [SLOT_W-1:0] write_slot;
  logic              wrapped;   // window store fully written at least once

  // datapath registers
  val_t                     x_reg;   // section input / final output
  val_t                     w_reg;
  logic signed [PROD_W-1:0] prod;
  logic signed [PACC_W-1:0] pacc;
  logic signed [MSUM_W-1:0] msum;
  acc_t                     acc;
  logic                     wear_reg;
  logic signed [FILT_W-1:0] filt_reg;
  logic [MAG_W-1:0]         mag_reg;
  logic [MAG_W-1:0]         env_q;

  logic accept;
  assign s_axis_tready = (state == ST_IDLE) && !rst;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // ---- shared multiplier -------------------------------------------------
  coef_t                    coef_sel;
  val_t                     op_full;
  logic signed [OPH_W-1:0]  op_half;
  logic signed [PROD_W-1:0] mul_out;
  logic signed [MSUM_W-1:0] msum_next;
  acc_t                     term;
  val_t                     fin_val;

  assign coef_sel = coef_of(sec, pidx);

  always_comb begin
    unique case (pidx) inside
      P_FB1, P_FF1: op_full = dly1[sec];
      P_FB2, P_FF2: op_full = dly2[sec];
      P_FF0:        op_full = w_reg;
      default:      op_full = '0;
    endcase
  end

  // low half is unsigned, high half carries the sign
  assign op_half = phase ? {op_full[VAL_W-1], op_full[VAL_W-1:HALF_W]}
                         : {1'b0, op_full[HALF_W-1:0]};
  assign mul_out = PROD_W'(coef_sel) * PROD_W'(op_half);

  // floor(c*v / 2^22) = floor((c*hi + floor(c*lo / 2^20)) / 4)
  assign msum_next = MSUM_W'(prod) + MSUM_W'(pacc);
  assign term      = msum[MSUM_W-1:2];
  assign fin_val   = sat_val(acc + term);

  // ---- post-filter -------------------------------------------------------
  val_t                      adj;
  logic signed [WHOLE_W-1:0] whole;
  logic signed [FILT_W-1:0]  filt_next;
  logic [MAG_W-1:0]          mag_next;

  always_comb begin
    // round toward zero: bias negatives before the shift
    adj   = x_reg + (x_reg[VAL_W-1] ? val_t'({FRAC_W{1'b1}}) : '0);
    whole = adj[VAL_W-1:FRAC_W];
    if (whole > LIM_POS) begin
      filt_next = FILT_W'(LIM_POS);
    end else if (whole < LIM_NEG) begin
      filt_next = FILT_W'(LIM_NEG);
    end else begin
      filt_next = whole[FILT_W-1:0];
    end
    mag_next = filt_next[FILT_W-1] ? MAG_W'(-filt_next) : filt_next[MAG_W-1:0];
  end

  // ---- window ------------------------------------------------------------
  logic [MAG_W-1:0] ram_rdata;
  logic [MAG_W-1:0] old_mag;
  logic [SUM_W-1:0] sum_next;

  assign old_mag  = wrapped ? ram_rdata : '0;
  assign sum_next = window_sum - SUM_W'(old_mag) + SUM_W'(mag_reg);

  emgbp_ram #(
    .WIDTH (MAG_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (state == ST_WIN),
    .waddr (write_slot),
    .wdata (mag_reg),
    .re    (accept),
    .raddr (write_slot),
    .rdata (ram_rdata)
  );

  // ---- envelope: window mean ---------------------------------------------
  logic [EPROD_W-1:0] env_prod;

  assign env_prod = EPROD_W'(window_sum) * EPROD_W'(RECIP);

  // ---- control -----------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      sec        <= '0;
      pidx       <= P_FB1;
      phase      <= 1'b0;
      window_sum <= '0;
      write_slot <= '0;
      wrapped    <= 1'b0;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < SECTIONS; i++) begin
        dly1[i] <= '0;
        dly2[i] <= '0;
      end
    end else begin
      if (state == ST_OUT && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            sec   <= '0;
            pidx  <= P_FB1;
            phase <= 1'b0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          phase <= ~phase;
          if (phase) begin
            if (pidx == P_FF0) begin
              // section done: shift its delay line
              dly2[sec] <= dly1[sec];
              dly1[sec] <= w_reg;
              pidx      <= P_FB1;
              if (sec == SEC_W'(SECTIONS - 1)) begin
                state <= ST_TAILA;
              end else begin
                sec <= sec + 1'b1;
              end
            end else begin
              pidx <= pidx + 1'b1;
            end
          end
        end
        ST_TAILA: state <= ST_TAILB;
        ST_TAILB: state <= ST_POST;
        ST_POST:  state <= ST_WIN;
        ST_WIN: begin
          window_sum <= sum_next;
          if (write_slot == LAST_SLOT) begin
            write_slot <= '0;
            wrapped    <= 1'b1;
          end else begin
            write_slot <= write_slot + 1'b1;
          end
          state <= ST_ENV;
        end
        ST_ENV: state <= ST_OUT;
        ST_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---- datapath ----------------------------------------------------------
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          x_reg    <= val_t'({s_axis_tdata[RAW_W-1:0] & RAW_MASK, {FRAC_W{1'b0}}});
          wear_reg <= s_axis_tuser[0];
        end
      end
      ST_RUN: begin
        prod <= mul_out;
        if (!phase) begin
          msum <= msum_next;           // merge halves of the previous product
        end else begin
          pacc <= prod[PROD_W-1:HALF_W];
          unique case (pidx)
            P_FB1: if (sec != '0) x_reg <= fin_val;  // previous section output
            P_FB2: acc   <= acc_t'(x_reg) + term;
            P_FF1: w_reg <= fin_val;
            P_FF2: acc   <= term;
            P_FF0: acc   <= acc + term;
            default: acc <= acc;
          endcase
        end
      end
      ST_TAILA: msum  <= msum_next;
      ST_TAILB: x_reg <= fin_val;
      ST_POST: begin
        filt_reg <= filt_next;
        mag_reg  <= mag_next;
      end
      ST_ENV: env_q <= env_prod[RECIP_SH+MAG_W-1:RECIP_SH];
      ST_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          m_axis_tdata <= {{OUT_PAD_W{1'b0}}, env_q, 1'b0, filt_reg};
          m_axis_tuser <= wear_reg;
        end
      end
      default: acc <= acc;
    endcase
  end

  // ---- assertions --------------------------------------------------------
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("block took a second item while busy");

  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    window_sum <= SUM_MAX)
    else $error("window sum above full-scale bound");

  a_env_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ENV) |=> state == ST_OUT)
    else $error("envelope step did not hand over to output");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == ST_OUT)
    else $error("result shown outside output load");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for emg_bandpass_envelope_top: streams sample items, predicts the
// four-section bandpass and the windowed envelope, and compares every result item.
// Needs emgbp_pkg and the block's RTL only; no files, no arguments.
module tb_top;
  import emgbp_pkg::*;

  localparam int     WIN_DEPTH    = 64;
  localparam int     N_ITEMS      = 900;
  localparam int     PHASE_ITEMS  = 100;     // items per pacing phase
  localparam int     CYCLE_LIMIT  = 400000;  // watchdog limit on the whole run, with sink stalls
  localparam int     DRAIN_CYCLES = 80;      // wait after the last result before the verdict
  localparam int     FILT_LIMIT   = 8191;
  localparam int     Q16_ONE      = 65536;
  localparam longint SEC_MAX      = 64'sd549755813887;   // 2^39 - 1
  localparam longint SEC_MIN      = -64'sd549755813888;  // -2^39

  // Pacing of the two stream sides, cycled every PHASE_ITEMS accepted items.
  typedef enum logic [1:0] {
    PACE_FREE, PACE_SEND_GAPS, PACE_SINK_STALLS, PACE_BOTH
  } pace_t;

  typedef struct packed {
    logic [RAW_W-1:0] raw;
    logic             wear;
  } sample_t;

  typedef struct packed {
    logic signed [FILT_W-1:0] filt;
    logic [ENV_W-1:0]         env;
    logic                     wear;
  } emg_result_t;

  typedef struct {
    longint f1, f2, b0, b1, b2;
  } biquad_coefs_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // [11:0] raw_sample, [15:12] zero
  logic [0:0]            s_axis_tuser = '0;  // [0] wear_detect
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;       // [13:0] filtered_value, [27:14] envelope_value
  logic [0:0]            m_axis_tuser;       // [0] wear_flag

  emg_bandpass_envelope_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 20-unit clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: own copy of the cascade delays and the rectified window.
  // ---------------------------------------------------------------------------
  longint           sec_w1 [SECTIONS];
  longint           sec_w2 [SECTIONS];
  logic [MAG_W-1:0] win_mags [WIN_DEPTH];
  logic [18:0]      win_total;
  int               win_slot;

  sample_t     samples_waiting[$];  // stimulus not yet offered
  emg_result_t outputs_due[$];      // predictions, oldest first
  sample_t     next_sample;
  emg_result_t want;
  logic signed [FILT_W-1:0] got_filt;
  logic [ENV_W-1:0]         got_env;
  logic                     got_wear;

  int    samples_taken = 0;
  int    results_seen  = 0;
  int    errors        = 0;
  int    n_clamped     = 0;
  int    n_worn        = 0;
  int    peak_env      = 0;
  int    cycles        = 0;
  pace_t pace;

  assign pace = pace_t'((samples_taken / PHASE_ITEMS) % 4);

  // Q2.22 coefficients per section: feedback f1, f2 and feed-forward b0, b1, b2.
  function automatic biquad_coefs_t section_coefs(int sec);
    biquad_coefs_t k;
    case (sec)
      0: begin
        k.f1 = 2315062; k.f2 = -2535948; k.b0 = 9374; k.b1 = 18748; k.b2 = 9374;
      end
      1: begin
        k.f1 = 3608635; k.f2 = -2663884; k.b0 = 4194304; k.b1 = 8388608; k.b2 = 4194304;
      end
      2: begin
        k.f1 = 1567296; k.f2 = -3407818; k.b0 = 4194304; k.b1 = -8388608; k.b2 = 4194304;
      end
      default: begin
        k.f1 = 4848665; k.f2 = -3555159; k.b0 = 4194304; k.b1 = -8388608; k.b2 = 4194304;
      end
    endcase
    return k;
  endfunction

  // Exact product, then floor shift by the 22 coefficient fraction bits.
  // |coef| <= 2^23 and |value| <= 2^39, so the product fits a longint.
  function automatic longint q22_mul(longint c, longint v);
    return (c * v) >>> 22;
  endfunction

  function automatic longint sat40(longint v);
    if (v > SEC_MAX) return SEC_MAX;
    if (v < SEC_MIN) return SEC_MIN;
    return v;
  endfunction

  // One sample through the cascade, clamp/rectify, window update, envelope.
  function automatic emg_result_t bandpass_envelope_step(logic [RAW_W-1:0] raw, logic wear);
    emg_result_t   r;
    biquad_coefs_t k;
    longint        v, w, d1, d2, whole;
    logic [MAG_W-1:0] mag;
    logic [18:0]   quo;
    int            s;
    v = longint'(raw) * Q16_ONE;
    for (s = 0; s < SECTIONS; s++) begin
      k  = section_coefs(s);
      d1 = sec_w1[s];
      d2 = sec_w2[s];
      w  = sat40(v + q22_mul(k.f1, d1) + q22_mul(k.f2, d2));
      v  = sat40(q22_mul(k.b0, w) + q22_mul(k.b1, d1) + q22_mul(k.b2, d2));
      sec_w2[s] = d1;
      sec_w1[s] = w;
    end
    whole = v / Q16_ONE;  // truncates toward zero
    if (whole > FILT_LIMIT || whole < -FILT_LIMIT) n_clamped++;
    if (whole > FILT_LIMIT) whole = FILT_LIMIT;
    if (whole < -FILT_LIMIT) whole = -FILT_LIMIT;
    mag = MAG_W'(whole < 0 ? -whole : whole);
    win_total = win_total - 19'(win_mags[win_slot]) + 19'(mag);
    win_mags[win_slot] = mag;
    win_slot = (win_slot + 1) % WIN_DEPTH;
    quo    = win_total / WIN_DEPTH;
    r.filt = FILT_W'(whole);
    r.env  = ENV_W'(quo * 2);
    r.wear = wear;
    if (int'(r.env) > peak_env) peak_env = int'(r.env);
    if (wear) n_worn++;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic add_sample(int raw, bit wear);
    sample_t x;
    x.raw  = raw[RAW_W-1:0];
    x.wear = wear;
    samples_waiting.push_back(x);
  endtask

  // Full or partial swing square wave; periods near 5..7 samples sit in the passband.
  task automatic add_square(int period, int lo, int hi, int count, bit wear);
    int i;
    for (i = 0; i < count; i++) begin
      add_sample(((i % period) < (period / 2)) ? hi : lo, wear);
    end
  endtask

  function automatic int send_idle_pct(pace_t p);
    case (p)
      PACE_SEND_GAPS: return 63;
      PACE_BOTH:      return 34;
      default:        return 0;
    endcase
  endfunction

  function automatic int sink_stall_pct(pace_t p);
    case (p)
      PACE_SINK_STALLS: return 63;
      PACE_BOTH:        return 34;
      default:          return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued samples; predicts each one on acceptance.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        outputs_due.push_back(bandpass_envelope_step(s_axis_tdata[RAW_W-1:0], s_axis_tuser[0]));
        samples_taken++;
      end
      // Valid only changes once the current item is gone (or none is offered).
      if (!s_axis_tvalid || s_axis_tready) begin
        if (samples_waiting.size() != 0 && $urandom_range(99) >= send_idle_pct(pace)) begin
          next_sample = samples_waiting.pop_front();
          s_axis_tdata  <= {{(IN_DATA_W-RAW_W){1'b0}}, next_sample.raw};
          s_axis_tuser  <= next_sample.wear;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Sink back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct(pace));
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: each accepted result against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (outputs_due.size() == 0) begin
        $error("result item with no sample outstanding: tdata=%h", m_axis_tdata);
        errors++;
      end else begin
        want     = outputs_due.pop_front();
        got_filt = m_axis_tdata[FILT_W-1:0];
        got_env  = m_axis_tdata[FILT_W+ENV_W-1:FILT_W];
        got_wear = m_axis_tuser[0];
        if (got_filt !== want.filt) begin
          $error("filtered_value: expected %0d, got %0d", want.filt, got_filt);
          errors++;
        end
        if (got_env !== want.env) begin
          $error("envelope_value: expected %0d, got %0d", want.env, got_env);
          errors++;
        end
        if (got_wear !== want.wear) begin
          $error("wear_flag: expected %0b, got %0b", want.wear, got_wear);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, outputs_due.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Run control: predictor reset, stimulus, reset release, drain, verdict.
  // ---------------------------------------------------------------------------
  initial begin : run_control
    int i, kind, len, period, lo, hi, level, step;
    bit wear_now;
    for (i = 0; i < SECTIONS; i++) begin
      sec_w1[i] = 0;
      sec_w2[i] = 0;
    end
    for (i = 0; i < WIN_DEPTH; i++) win_mags[i] = '0;
    win_total = '0;
    win_slot  = 0;

    // Directed: field extremes, bit patterns, both wear levels, then a
    // full-swing tone in the passband to push toward clamping/saturation.
    add_sample(0, 1'b0);
    add_sample(4095, 1'b1);
    add_sample(12'hAAA, 1'b0);
    add_sample(12'h555, 1'b1);
    add_sample(0, 1'b1);
    add_sample(4095, 1'b0);
    add_square(6, 0, 4095, 18, 1'b1);

    // Random: mostly tone bursts of random period and swing (these excite the
    // bandpass), plus white noise, flat stretches and ramps. The window wraps
    // many times over.
    while (samples_waiting.size() < N_ITEMS) begin
      kind     = $urandom_range(99);
      len      = $urandom_range(40, 8);
      wear_now = $urandom_range(1);
      if (kind < 55) begin
        period = $urandom_range(12, 3);
        lo     = $urandom_range(1500);
        hi     = $urandom_range(4095, 2500);
        if ($urandom_range(3) == 0) begin
          lo = 0;
          hi = 4095;
        end
        add_square(period, lo, hi, len, wear_now);
      end else if (kind < 80) begin
        for (i = 0; i < len; i++) add_sample($urandom_range(4095), $urandom_range(1));
      end else if (kind < 90) begin
        level = ($urandom_range(2) == 0) ? 4095 : $urandom_range(4095);
        for (i = 0; i < len; i++) add_sample(level, wear_now);
      end else begin
        level = $urandom_range(4095);
        step  = $urandom_range(600, 1);
        for (i = 0; i < len; i++) add_sample((level + i * step) % 4096, wear_now);
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (samples_waiting.size() != 0 || s_axis_tvalid || outputs_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Streamed %0d samples (%0d worn) through the bandpass; %0d results checked,",
             samples_taken, n_worn, results_seen);
    $display("  %0d clamped outputs, envelope peak %0d, under free, gapped and stalled pacing.",
             n_clamped, peak_env);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== emg_bandpass_envelope_top.f =====
src/emgbp_pkg.sv
src/emgbp_ram.sv
src/emg_bandpass_envelope_top.sv
bench/tb_top.sv
